[sv/mash_clock_divider_setup_defines.svh]
// Assertion helpers for the divider set-up block
`ifndef MASH_CLOCK_DIVIDER_SETUP_DEFINES_SVH
`define MASH_CLOCK_DIVIDER_SETUP_DEFINES_SVH

`define MCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/mcd_pkg.sv]
package mcd_pkg;

  localparam int DIV_BITS = 12;
  localparam int DW = 42;
  localparam int BW = 32;
  localparam logic [DIV_BITS-1:0] DIV_MAX = {DIV_BITS{1'b1}};
  localparam logic [31:0] FILT_MAX_HZ = 32'd25000000;
  localparam logic [31:0] OUT_MAX_HZ = 32'd125000000;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_ZERO     = 3'd1,
    ERR_HIGH     = 3'd2,
    ERR_SRC_LOW  = 3'd3,
    ERR_SRC_HIGH = 3'd4,
    ERR_OVER     = 3'd5,
    ERR_DIV_LOW  = 3'd6
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVI, S_DIVF, S_DISP, S_AVG, S_MAX, S_MIN, S_INT, S_CHK
  } state_t;

  typedef struct packed {
    logic          go;
    logic [DW-1:0] dividend;
    logic [BW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [BW-1:0] rem;
  } div_rsp_t;

  function automatic logic [2:0] src_map(input logic [2:0] kind);
    logic [2:0] r;
    unique case (kind)
      3'd0: r = 3'd1;
      3'd1: r = 3'd4;
      3'd2: r = 3'd5;
      3'd3: r = 3'd6;
      3'd4: r = 3'd7;
      3'd5: r = 3'd2;
      3'd6: r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // divider offsets for the fastest and slowest instantaneous edge
  function automatic logic [1:0] off_hi(input logic [1:0] lvl);
    logic [1:0] r;
    unique case (lvl)
      2'd2: r = 2'd1;
      2'd3: r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] off_lo(input logic [1:0] lvl);
    logic [2:0] r;
    unique case (lvl)
      2'd2: r = 3'd2;
      2'd3: r = 3'd4;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

[sv/mcd_div.sv]
module mcd_div (
  input  logic              clk,
  input  logic              rst,
  input  mcd_pkg::div_req_t req,
  output mcd_pkg::div_rsp_t rsp
);
  import mcd_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] a;
  logic [DW-1:0] q;
  logic [BW-1:0] b;
  logic [BW-1:0] r;
  logic [BW:0]   r_sh;
  logic          ge;
  logic [BW:0]   r_sub;

  assign r_sh  = {r, a[DW-1]};
  assign ge    = r_sh >= {1'b0, b};
  assign r_sub = r_sh - {1'b0, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !busy) begin
      a <= req.dividend;
      b <= req.divisor;
      r <= '0;
      q <= '0;
    end else if (busy) begin
      a <= {a[DW-2:0], 1'b0};
      r <= ge ? r_sub[BW-1:0] : r_sh[BW-1:0];
      q <= {q[DW-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = r;

endmodule

[sv/mash_clock_divider_setup.sv]
// channel  | handshake     | words
// ---------+---------------+------------------------------------------------
// request  | start / busy  | source_hz target_hz filter_level source_kind
// result   | valid strobe  | error_code int_divider frac_divider mash_mode
//          |               | avg_out_hz min_out_hz max_out_hz source_code
// One 42-step restoring divider serves every quotient.
// An item needs 2 divisions, 3 per filter level tried and 1 in integer mode:
// up to 12 divisions in all; target errors report without a division.
// busy is high from acceptance to the result strobe, not for target errors; reset idles.
// The result shows for one cycle under valid and cannot be stalled.
`include "mash_clock_divider_setup_defines.svh"

module mash_clock_divider_setup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 source_hz,
  input  logic [31:0]                 target_hz,
  input  logic [1:0]                  filter_level,
  input  logic [2:0]                  source_kind,
  output logic                        valid,
  output logic [2:0]                  error_code,
  output logic [mcd_pkg::DIV_BITS-1:0] int_divider,
  output logic [10:0]                 frac_divider,
  output logic [1:0]                  mash_mode,
  output logic [31:0]                 avg_out_hz,
  output logic [31:0]                 min_out_hz,
  output logic [31:0]                 max_out_hz,
  output logic [2:0]                  source_code
);
  import mcd_pkg::*;

  state_t state, state_next;
  div_req_t req;
  div_rsp_t rsp;

  logic [31:0]         src;
  logic [31:0]         avg;
  logic [1:0]          filt;
  logic [1:0]          lvl;
  logic [2:0]          scode;
  logic [DIV_BITS-1:0] divi;
  logic [10:0]         divf;
  logic [1:0]          mash;
  logic [31:0]         favg, fmin, fmax;
  logic [DIV_BITS-1:0] divi_inc;
  logic [31:0]         divi_w;
  logic [31:0]         frac_w;
  logic                emit;
  err_t                emit_err;

  mcd_div u_div (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign divi_w   = {{(32-DIV_BITS){1'b0}}, divi};
  assign frac_w   = {{(22-DIV_BITS){1'b0}}, divi, 10'b0} + {21'b0, divf};
  assign divi_inc = (divf > 11'd511 && divi != DIV_MAX) ? divi + 1'b1 : divi;
  assign busy     = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    req.go       = 1'b0;
    req.dividend = {10'b0, src};
    req.divisor  = avg;
    emit         = 1'b0;
    emit_err     = ERR_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (target_hz == 32'd0) begin
            emit = 1'b1;
            emit_err = ERR_ZERO;
          end else if (target_hz > OUT_MAX_HZ ||
                       (filter_level != 2'd0 && target_hz > FILT_MAX_HZ)) begin
            emit = 1'b1;
            emit_err = ERR_HIGH;
          end else begin
            req.go       = 1'b1;
            req.dividend = {10'b0, source_hz};
            req.divisor  = target_hz;
            state_next   = S_DIVI;
          end
        end
      end
      S_DIVI: begin
        if (rsp.done) begin
          if (rsp.quot == '0) begin
            emit = 1'b1;
            emit_err = ERR_SRC_LOW;
            state_next = S_IDLE;
          end else if (rsp.quot[DW-1:DIV_BITS] != '0) begin
            emit = 1'b1;
            emit_err = ERR_SRC_HIGH;
            state_next = S_IDLE;
          end else begin
            req.go       = 1'b1;
            req.dividend = {rsp.rem, 10'b0} + {11'b0, avg[31:1]};
            state_next   = S_DIVF;
          end
        end
      end
      S_DIVF: if (rsp.done) state_next = S_DISP;
      S_DISP: begin
        unique case (filt)
          2'd0: begin
            req.go      = 1'b1;
            req.divisor = {{(32-DIV_BITS){1'b0}}, divi_inc};
            state_next  = S_INT;
          end
          2'd1: begin
            req.go = 1'b1;
            req.dividend = {src, 10'b0};
            req.divisor = frac_w;
            state_next = S_AVG;
          end
          2'd2: begin
            if (divi > DIV_BITS'(1)) begin
              req.go = 1'b1;
              req.dividend = {src, 10'b0};
              req.divisor = frac_w;
              state_next = S_AVG;
            end
          end
          default: begin
            if (divi > DIV_BITS'(3)) begin
              req.go = 1'b1;
              req.dividend = {src, 10'b0};
              req.divisor = frac_w;
              state_next = S_AVG;
            end
          end
        endcase
      end
      S_AVG: begin
        if (rsp.done) begin
          req.go      = 1'b1;
          req.divisor = divi_w - {30'b0, off_hi(lvl)};
          state_next  = S_MAX;
        end
      end
      S_MAX: begin
        if (rsp.done) begin
          req.go      = 1'b1;
          req.divisor = divi_w + {29'b0, off_lo(lvl)};
          state_next  = S_MIN;
        end
      end
      S_MIN: begin
        if (rsp.done) state_next = (fmax > FILT_MAX_HZ) ? S_DISP : S_CHK;
      end
      S_INT: begin
        if (rsp.done) begin
          if (rsp.quot > {10'b0, OUT_MAX_HZ}) begin
            emit = 1'b1;
            emit_err = ERR_OVER;
            state_next = S_IDLE;
          end else begin
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        emit = 1'b1;
        state_next = S_IDLE;
        if ((mash == 2'd1 && divi < DIV_BITS'(2)) ||
            (mash == 2'd2 && divi < DIV_BITS'(3)) ||
            (mash == 2'd3 && divi < DIV_BITS'(5)))
          emit_err = ERR_DIV_LOW;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        src   <= source_hz;
        avg   <= target_hz;
        filt  <= filter_level;
        scode <= src_map(source_kind);
      end
      S_DIVI: if (rsp.done) divi <= rsp.quot[DIV_BITS-1:0];
      S_DIVF: if (rsp.done) divf <= rsp.quot[10:0];
      S_DISP: begin
        unique case (filt)
          2'd0: begin
            divi <= divi_inc;
            divf <= '0;
            mash <= 2'd0;
          end
          2'd1: begin
            lvl  <= 2'd1;
            mash <= 2'd1;
            filt <= 2'd0;
          end
          2'd2: begin
            if (divi > DIV_BITS'(1)) begin
              lvl  <= 2'd2;
              mash <= 2'd2;
            end
            filt <= 2'd1;
          end
          default: begin
            if (divi > DIV_BITS'(3)) begin
              lvl  <= 2'd3;
              mash <= 2'd3;
            end
            filt <= 2'd2;
          end
        endcase
      end
      S_AVG: if (rsp.done) favg <= rsp.quot[31:0];
      S_MAX: if (rsp.done) fmax <= rsp.quot[31:0];
      S_MIN: if (rsp.done) fmin <= rsp.quot[31:0];
      S_INT: begin
        if (rsp.done) begin
          favg <= rsp.quot[31:0];
          fmin <= rsp.quot[31:0];
          fmax <= rsp.quot[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else valid <= emit;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      error_code  <= emit_err;
      source_code <= (state == S_IDLE) ? src_map(source_kind) : scode;
      if (emit_err == ERR_OK) begin
        int_divider  <= divi;
        frac_divider <= divf;
        mash_mode    <= mash;
        avg_out_hz   <= favg;
        min_out_hz   <= fmin;
        max_out_hz   <= fmax;
      end else begin
        int_divider  <= '0;
        frac_divider <= '0;
        mash_mode    <= '0;
        avg_out_hz   <= '0;
        min_out_hz   <= '0;
        max_out_hz   <= '0;
      end
    end
  end

  `MCD_ASSERT(a_err_clears, valid && error_code != ERR_OK |-> int_divider == '0 &&
              mash_mode == 2'd0 && max_out_hz == 32'd0, "error word carries settings")
  `MCD_ASSERT(a_idle_at_result, valid |-> !busy, "result while still busy")
  `MCD_ASSERT(a_zero_target, start && !busy && target_hz == 32'd0 |=>
              valid && error_code == ERR_ZERO, "zero target not reported")
  `MCD_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !valid, "not idle after reset")

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mcd_pkg::*;

  typedef struct packed {
    logic [2:0]          err;
    logic [DIV_BITS-1:0] divi;
    logic [10:0]         divf;
    logic [1:0]          mash;
    logic [31:0]         favg;
    logic [31:0]         fmin;
    logic [31:0]         fmax;
    logic [2:0]          src;
  } setup_t;

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] t;
    logic [1:0]  f;
    logic [2:0]  k;
    bit          typed;
    logic [2:0]  e;
    logic [2:0]  sc;
  } row_t;

  localparam int NROWS = 20;
  localparam int NRAND = 1230;
  localparam int WATCH_LIMIT = 20000;
  localparam longint unsigned LIM_FILT = 64'd25000000;
  localparam longint unsigned LIM_OUT = 64'd125000000;

  localparam row_t DIRECTED [NROWS] = '{
    '{32'd1000, 32'd0, 2'd0, 3'd0, 1'b1, ERR_ZERO, 3'd1},
    '{32'hffffffff, 32'd125000001, 2'd0, 3'd1, 1'b1, ERR_HIGH, 3'd4},
    '{32'hffffffff, 32'd25000001, 2'd1, 3'd2, 1'b1, ERR_HIGH, 3'd5},
    '{32'hffffffff, 32'hffffffff, 2'd3, 3'd3, 1'b1, ERR_HIGH, 3'd6},
    '{32'd0, 32'd1000, 2'd0, 3'd4, 1'b1, ERR_SRC_LOW, 3'd7},
    '{32'd4096, 32'd1, 2'd0, 3'd5, 1'b1, ERR_SRC_HIGH, 3'd2},
    '{32'hffffffff, 32'd1, 2'd3, 3'd6, 1'b1, ERR_SRC_HIGH, 3'd3},
    '{32'd130000000, 32'd125000000, 2'd0, 3'd7, 1'b1, ERR_OVER, 3'd0},
    '{32'd20000000, 32'd15000000, 2'd1, 3'd0, 1'b1, ERR_DIV_LOW, 3'd1},
    '{32'd4095, 32'd1, 2'd0, 3'd1, 1'b0, ERR_OK, 3'd0},
    '{32'd150000000, 32'd100000000, 2'd0, 3'd2, 1'b0, ERR_OK, 3'd0},
    '{32'd250000000, 32'd125000000, 2'd0, 3'd3, 1'b0, ERR_OK, 3'd0},
    '{32'd500000000, 32'd7300000, 2'd3, 3'd4, 1'b0, ERR_OK, 3'd0},
    '{32'd500000000, 32'd7300000, 2'd2, 3'd5, 1'b0, ERR_OK, 3'd0},
    '{32'd500000000, 32'd7300000, 2'd1, 3'd6, 1'b0, ERR_OK, 3'd0},
    '{32'd100000000, 32'd24000000, 2'd3, 3'd7, 1'b0, ERR_OK, 3'd0},
    '{32'd60000000, 32'd25000000, 2'd2, 3'd0, 1'b0, ERR_OK, 3'd0},
    '{32'd54000000, 32'd19200000, 2'd3, 3'd1, 1'b0, ERR_OK, 3'd0},
    '{32'hffffffff, 32'd1048577, 2'd3, 3'd2, 1'b0, ERR_OK, 3'd0},
    '{32'd1, 32'd1, 2'd0, 3'd3, 1'b0, ERR_OK, 3'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [31:0] source_hz = '0;
  logic [31:0] target_hz = '0;
  logic [1:0] filter_level = '0;
  logic [2:0] source_kind = '0;
  logic valid;
  logic [2:0] error_code;
  logic [DIV_BITS-1:0] int_divider;
  logic [10:0] frac_divider;
  logic [1:0] mash_mode;
  logic [31:0] avg_out_hz;
  logic [31:0] min_out_hz;
  logic [31:0] max_out_hz;
  logic [2:0] source_code;

  setup_t pending[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit done_driving = 1'b0;

  always #6 clk = ~clk;

  mash_clock_divider_setup uut (.*);

  function automatic setup_t calc_setup(logic [31:0] s, logic [31:0] t, logic [1:0] f,
                                        logic [2:0] k);
    logic [2:0] kind_map [8] = '{3'd1, 3'd4, 3'd5, 3'd6, 3'd7, 3'd2, 3'd3, 3'd0};
    longint unsigned sh, ah, dmax, divi, divf, rmdr, favg, fmin, fmax, mash;
    int lvl;
    bit set, more;
    setup_t r;
    r = '0;
    r.src = kind_map[k];
    sh = s;
    ah = t;
    lvl = f;
    dmax = (64'd1 << DIV_BITS) - 1;
    favg = 0; fmin = 0; fmax = 0; mash = 0;
    set = 0; more = 1;
    if (ah == 0) begin
      r.err = ERR_ZERO;
      return r;
    end
    if (ah > LIM_OUT || (lvl != 0 && ah > LIM_FILT)) begin
      r.err = ERR_HIGH;
      return r;
    end
    divi = sh / ah;
    if (divi == 0) begin
      r.err = ERR_SRC_LOW;
      return r;
    end
    if (divi > dmax) begin
      r.err = ERR_SRC_HIGH;
      return r;
    end
    rmdr = sh - divi * ah;
    divf = (rmdr * 1024 + ah / 2) / ah;
    do begin
      case (lvl)
        0: begin
          more = 0;
          if (divf > 511 && divi < dmax) divi++;
          divf = 0;
          favg = sh / divi;
          fmin = favg;
          fmax = favg;
          mash = 0;
          set = 1;
          if (fmax > LIM_OUT) begin
            r.err = ERR_OVER;
            return r;
          end
        end
        1: begin
          favg = (sh * 1024) / (divi * 1024 + divf);
          fmax = sh / divi;
          fmin = sh / (divi + 1);
          mash = 1;
          set = 1;
          lvl = 0;
        end
        2: begin
          if (divi > 1) begin
            favg = (sh * 1024) / (divi * 1024 + divf);
            fmax = sh / (divi - 1);
            fmin = sh / (divi + 2);
            mash = 2;
            set = 1;
          end
          lvl = 1;
        end
        default: begin
          if (divi > 3) begin
            favg = (sh * 1024) / (divi * 1024 + divf);
            fmax = sh / (divi - 3);
            fmin = sh / (divi + 4);
            mash = 3;
            set = 1;
          end
          lvl = 2;
        end
      endcase
    end while (more && (!set || fmax > LIM_FILT));
    if ((mash == 1 && divi < 2) || (mash == 2 && divi < 3) || (mash == 3 && divi < 5)) begin
      r.err = ERR_DIV_LOW;
      return r;
    end
    r.err = ERR_OK;
    r.divi = divi[DIV_BITS-1:0];
    r.divf = divf[10:0];
    r.mash = mash[1:0];
    r.favg = favg[31:0];
    r.fmin = fmin[31:0];
    r.fmax = fmax[31:0];
    return r;
  endfunction

  task automatic send_word(logic [31:0] s, logic [31:0] t, logic [1:0] f, logic [2:0] k,
                           bit gap_ok);
    int gap;
    gap = (gap_ok && $urandom_range(0, 99) < 19) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    source_hz <= s;
    target_hz <= t;
    filter_level <= f;
    source_kind <= k;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    row_t row;
    setup_t e;
    logic [31:0] s, t;
    logic [1:0] f;
    logic [2:0] k;
    longint unsigned d, sv;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NROWS; i++) begin
      row = DIRECTED[i];
      if (row.typed) begin
        e = '0;
        e.err = row.e;
        e.src = row.sc;
      end else begin
        e = calc_setup(row.s, row.t, row.f, row.k);
      end
      send_word(row.s, row.t, row.f, row.k, 1'b1);
      pending.push_back(e);
    end
    for (int i = 0; i < NRAND; i++) begin
      f = $urandom_range(0, 3);
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 99) < 80) begin
        t = (f != 0) ? $urandom_range(1, 25000000) : $urandom_range(1, 125000000);
        if ($urandom_range(0, 3) == 0) t = $urandom_range(1, 2000);
        d = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4095);
        sv = longint'(t) * d + $urandom_range(0, t - 1);
        s = (sv > 64'hffffffff) ? 32'hffffffff : sv[31:0];
      end else begin
        s = $urandom;
        t = ($urandom_range(0, 1) == 0) ? $urandom : ($urandom >> $urandom_range(4, 31));
      end
      if (i == 600) begin
        start <= 1'b0;
        do @(posedge clk); while (pending.size() > 0);
      end
      send_word(s, t, f, k, !(i > 300 && i < 600));
      pending.push_back(calc_setup(s, t, f, k));
    end
    start <= 1'b0;
    done_driving <= 1'b1;
    do @(posedge clk); while (pending.size() > 0);
    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("mash_clock_divider_setup: match");
    end else begin
      $display("mash_clock_divider_setup: mismatch");
    end
    $finish;
  end

  always @(posedge clk) begin
    setup_t e, a;
    if (!rst && valid) begin
      a = '{error_code, int_divider, frac_divider, mash_mode,
            avg_out_hz, min_out_hz, max_out_hz, source_code};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", a);
      end else begin
        e = pending.pop_front();
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch: exp %p got %p", e, a);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || (done_driving && pending.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("mash_clock_divider_setup: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule
